// File: design/sbad_pkg.sv
// Shared types and constants for the spectrogram box-average decimator.
// No dependencies; used by sbad_div and the core top level.
package sbad_pkg;

    // default sizes
    localparam int ACC_DEPTH_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 32;

    // fixed field widths
    localparam int SUM_W     = 48;   // box accumulator width
    localparam int AVG_W     = 32;   // output average width
    localparam int DIVISOR_W = 17;   // widest divisor (factor product up to 65536)
    localparam int SHORT_OPS = 17;   // quotient bits for index and setup divides
    localparam int CFG_W     = 17;   // widest configuration register
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_FACTOR = 3'd0,
        REG_FREQ_FACTOR = 3'd1,
        REG_TIME_OFFSET = 3'd2,
        REG_FREQ_OFFSET = 3'd3,
        REG_ROW_POINTS  = 3'd4,
        REG_CHANNELS    = 3'd5,
        REG_TOTAL_ROWS  = 3'd6
    } t_cfg_reg;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CFG_NF,
        S_CFG_NT,
        S_CFG_LIM,
        S_QDIV,
        S_READ,
        S_ACC,
        S_AVG,
        S_HOLD
    } t_state;

    // divider command
    typedef struct packed {
        logic start;
        logic long_op;   // full 48 quotient bits instead of SHORT_OPS
    } t_div_ctl;

endpackage

// File: design/sbad_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sbad_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: design/sbad_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sbad_pkg for widths and the command struct.
module sbad_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sbad_pkg::t_div_ctl                 i_ctl,
    input  logic [sbad_pkg::SUM_W-1:0]         i_dividend,
    input  logic [sbad_pkg::DIVISOR_W-1:0]     i_divisor,
    output logic                               o_done,
    output logic [sbad_pkg::SUM_W-1:0]         o_quot,
    output logic [sbad_pkg::DIVISOR_W-1:0]     o_rem
);

    localparam int DW    = sbad_pkg::SUM_W;
    localparam int VW    = sbad_pkg::DIVISOR_W;
    localparam int CW    = $clog2(DW + 1);
    localparam int SHIFT = DW - sbad_pkg::SHORT_OPS;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_a;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;

    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        fits;

    // one restoring step
    always_comb begin
        trial = {r_rem, r_a[DW-1]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.long_op ? CW'(DW) : CW'(sbad_pkg::SHORT_OPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath; a short divide starts with the dividend pre-aligned
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a   <= i_ctl.long_op ? i_dividend : (i_dividend << SHIFT);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_a   <= {r_a[DW-2:0], fits};
            r_rem <= fits ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_a;
    assign o_rem  = r_rem;

endmodule

// File: design/spectrogram_box_average_decimator_core.sv
// Top level of the spectrogram box-average decimator: sequencer, counters, accumulator row.
// Depends on sbad_pkg, sbad_div and sbad_ram.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------------------
//  input    | i_in_valid / o_in_stall  | i_sample
//  output   | o_out_valid / i_out_stall| o_average o_out_row o_out_point
//           |                          | o_channel_index o_end_of_row
//  config   | i_cfg_we                 | i_cfg_index i_cfg_data
//
// One shared bit-serial divider sets the timing. A sample outside any box needs no divide;
// an accumulated sample runs an index divide, a RAM read and a write back (only the index
// divide when its box lies past the row limit), and one that closes a box a 48-bit mean
// divide as well, plus any output stall. Setup divides start once config writes stop, and
// no transaction is taken before they finish; a write during setup runs it again. Reset is
// synchronous, active low; the sum RAM is not cleared. A finished result waits in the
// output register while the next sample is taken.
module spectrogram_box_average_decimator_core #(
    parameter int ACC_DEPTH   = sbad_pkg::ACC_DEPTH_DEF,
    parameter int SAMPLE_BITS = sbad_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sbad_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sbad_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [sbad_pkg::AVG_W-1:0] o_average,
    output logic [15:0]                       o_out_row,
    output logic [11:0]                       o_out_point,
    output logic [3:0]                        o_channel_index,
    output logic                              o_end_of_row
);

    localparam int AW    = $clog2(ACC_DEPTH);
    localparam int SW    = sbad_pkg::SUM_W;
    localparam int VW    = sbad_pkg::DIVISOR_W;
    localparam logic [SW:0] SMAX = (SW+1)'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    // configuration registers
    logic [8:0]  r_tf, r_ff;
    logic [15:0] r_to;
    logic [11:0] r_fo;
    logic [12:0] r_rp;
    logic [4:0]  r_ch;
    logic [16:0] r_tr;

    // derived setup and raster counters
    logic        r_dirty;
    logic [12:0] r_nf_raw, r_nf;
    logic [16:0] r_nt;
    logic [15:0] r_row, n_row;
    logic [11:0] r_pc, n_pc;
    logic [3:0]  r_cc, n_cc;
    logic [7:0]  r_rib, n_rib;
    logic [15:0] r_orc, n_orc;

    // per-transaction snapshot
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [3:0]    r_s_cc;
    logic [7:0]    r_s_rib;
    logic [15:0]   r_s_orc;
    logic [11:0]   r_q;
    logic [8:0]    r_sub;
    logic [AW-1:0] r_idx;
    logic          r_neg;

    sbad_pkg::t_state r_state, n_state;

    // clamped configuration
    logic [8:0]  tf_c, ff_c;
    logic [12:0] rp_c;
    logic [4:0]  ch_c;
    logic [16:0] tr_c;

    always_comb begin
        tf_c = (r_tf == 9'd0) ? 9'd1 : ((r_tf > 9'd256) ? 9'd256 : r_tf);
        ff_c = (r_ff == 9'd0) ? 9'd1 : ((r_ff > 9'd256) ? 9'd256 : r_ff);
        rp_c = (r_rp == 13'd0) ? 13'd1 : ((r_rp > 13'd4096) ? 13'd4096 : r_rp);
        ch_c = (r_ch == 5'd0) ? 5'd1 : ((r_ch > 5'd16) ? 5'd16 : r_ch);
        tr_c = (r_tr == 17'd0) ? 17'd1 : ((r_tr > 17'd65536) ? 17'd65536 : r_tr);
    end

    // divider and memory
    sbad_pkg::t_div_ctl div_ctl;
    logic [SW-1:0] div_dividend;
    logic [VW-1:0] div_divisor;
    logic          div_done;
    logic [SW-1:0] div_quot;
    logic [VW-1:0] div_rem;

    sbad_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    logic          mem_we, mem_re;
    logic [SW-1:0] mem_rdata;
    logic [SW-1:0] sum_new;

    sbad_ram #(.WIDTH(SW), .DEPTH(ACC_DEPTH)) u_sums (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_idx),
        .i_wdata (sum_new),
        .i_re    (mem_re),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    // transaction accept and box membership
    logic        accept;
    logic        row_live, take;
    logic [11:0] rel;

    always_comb begin
        row_live = ({1'b0, r_row} >= {1'b0, r_to}) && ({1'b0, r_orc} < r_nt);
        take     = row_live && (r_pc >= r_fo) && ({1'b0, r_cc} < ch_c);
        rel      = r_pc - r_fo;
        accept   = i_in_valid && !o_in_stall;
    end

    // raster counter advance
    logic [4:0]  cc_inc;
    logic [12:0] pc_inc;
    logic [8:0]  rib_inc;
    logic [16:0] row_inc;

    always_comb begin
        cc_inc  = {1'b0, r_cc} + 5'd1;
        pc_inc  = {1'b0, r_pc} + 13'd1;
        rib_inc = {1'b0, r_rib} + 9'd1;
        row_inc = {1'b0, r_row} + 17'd1;
        n_cc  = r_cc;
        n_pc  = r_pc;
        n_rib = r_rib;
        n_orc = r_orc;
        n_row = r_row;
        if (accept) begin
            n_cc = cc_inc[3:0];
            if (cc_inc >= ch_c) begin
                n_cc = '0;
                n_pc = pc_inc[11:0];
                if (pc_inc >= rp_c) begin
                    n_pc = '0;
                    if (row_live) begin
                        n_rib = rib_inc[7:0];
                        if (rib_inc >= tf_c) begin
                            n_rib = '0;
                            n_orc = r_orc + 16'd1;
                        end
                    end
                    n_row = row_inc[15:0];
                    if (row_inc >= tr_c) begin
                        n_row = '0;
                        n_rib = '0;
                        n_orc = '0;
                    end
                end
            end
        end
    end

    // accumulate with saturation
    logic signed [SW-1:0] samp_ext;
    logic signed [SW:0]   sum_wide;
    logic                 first_in_box, box_done;
    logic [SW-1:0]        sum_mag;
    logic [16:0]          idx_full;

    always_comb begin
        samp_ext     = SW'(r_sample);
        sum_wide     = {mem_rdata[SW-1], mem_rdata} + {samp_ext[SW-1], samp_ext};
        first_in_box = (r_s_rib == 8'd0) && (r_sub == 9'd0);
        if (first_in_box) begin
            sum_new = samp_ext;
        end else if (sum_wide[SW] != sum_wide[SW-1]) begin
            sum_new = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            sum_new = sum_wide[SW-1:0];
        end
        sum_mag  = sum_new[SW-1] ? (SW'(0) - sum_new) : sum_new;
        box_done = ({1'b0, r_s_rib} == tf_c - 9'd1) && (r_sub == ff_c - 9'd1);
        // entry of the box quotient just delivered by the divider
        idx_full = div_quot[11:0] * ch_c + {13'd0, r_s_cc};
    end

    // mean with saturation to the sample range
    logic [SW:0] quot_w, avg_w;

    always_comb begin
        quot_w = {1'b0, div_quot};
        if (!r_neg) begin
            avg_w = (quot_w > SMAX) ? SMAX : quot_w;
        end else if (quot_w > SMAX + (SW+1)'(1)) begin
            avg_w = (SW+1)'(0) - SMAX - (SW+1)'(1);
        end else begin
            avg_w = (SW+1)'(0) - quot_w;
        end
    end

    logic out_free, load_out;
    assign out_free = !o_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sbad_pkg::S_IDLE: begin
                if (r_dirty) begin
                    if (!i_cfg_we) begin
                        n_state = sbad_pkg::S_CFG_NF;
                    end
                end else if (accept && take) begin
                    n_state = sbad_pkg::S_QDIV;
                end
            end
            sbad_pkg::S_CFG_NF:  if (div_done) n_state = sbad_pkg::S_CFG_NT;
            sbad_pkg::S_CFG_NT:  if (div_done) n_state = sbad_pkg::S_CFG_LIM;
            sbad_pkg::S_CFG_LIM: if (div_done) n_state = sbad_pkg::S_IDLE;
            sbad_pkg::S_QDIV: begin
                if (div_done) begin
                    n_state = ({1'b0, div_quot[11:0]} < r_nf) ? sbad_pkg::S_READ
                                                              : sbad_pkg::S_IDLE;
                end
            end
            sbad_pkg::S_READ: n_state = sbad_pkg::S_ACC;
            sbad_pkg::S_ACC:  n_state = box_done ? sbad_pkg::S_AVG : sbad_pkg::S_IDLE;
            sbad_pkg::S_AVG:  if (div_done) n_state = sbad_pkg::S_HOLD;
            sbad_pkg::S_HOLD: if (out_free) n_state = sbad_pkg::S_IDLE;
            default:          n_state = sbad_pkg::S_IDLE;
        endcase
    end

    // state outputs: divider commands, memory strobes, handshake
    always_comb begin
        div_ctl      = '0;
        div_dividend = '0;
        div_divisor  = {8'd0, ff_c};
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        load_out     = 1'b0;
        o_in_stall   = 1'b1;
        unique case (r_state)
            sbad_pkg::S_IDLE: begin
                o_in_stall = r_dirty;
                if (r_dirty) begin
                    if (!i_cfg_we) begin
                        div_ctl.start = 1'b1;
                        div_dividend  = SW'((rp_c > {1'b0, r_fo}) ? rp_c - {1'b0, r_fo}
                                                                  : 13'd0);
                    end
                end else if (accept && take) begin
                    div_ctl.start = 1'b1;
                    div_dividend  = SW'(rel);
                end
            end
            sbad_pkg::S_CFG_NF: begin
                div_ctl.start = div_done;
                div_dividend  = SW'((tr_c > {1'b0, r_to}) ? tr_c - {1'b0, r_to} : 17'd0);
                div_divisor   = {8'd0, tf_c};
            end
            sbad_pkg::S_CFG_NT: begin
                div_ctl.start = div_done;
                div_dividend  = SW'(ACC_DEPTH);
                div_divisor   = {12'd0, ch_c};
            end
            sbad_pkg::S_READ: mem_re = 1'b1;
            sbad_pkg::S_ACC: begin
                mem_we          = 1'b1;
                div_ctl.start   = box_done;
                div_ctl.long_op = 1'b1;
                div_dividend    = sum_mag;
                div_divisor     = tf_c * ff_c;
            end
            sbad_pkg::S_HOLD: load_out = out_free;
            sbad_pkg::S_CFG_LIM, sbad_pkg::S_QDIV, sbad_pkg::S_AVG: ;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbad_pkg::S_IDLE;
            r_dirty     <= 1'b1;
            r_tf        <= 9'd1;
            r_ff        <= 9'd1;
            r_to        <= '0;
            r_fo        <= '0;
            r_rp        <= 13'd1;
            r_ch        <= 5'd1;
            r_tr        <= 17'd1;
            r_row       <= '0;
            r_pc        <= '0;
            r_cc        <= '0;
            r_rib       <= '0;
            r_orc       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_pc    <= n_pc;
            r_cc    <= n_cc;
            r_rib   <= n_rib;
            r_orc   <= n_orc;
            // setup clears the dirty flag when it starts; its divides read the live registers
            if (r_state == sbad_pkg::S_IDLE && r_dirty && !i_cfg_we) begin
                r_dirty <= 1'b0;
            end
            if (i_cfg_we) begin
                r_dirty <= 1'b1;
                unique case (i_cfg_index)
                    sbad_pkg::REG_TIME_FACTOR: r_tf <= i_cfg_data[8:0];
                    sbad_pkg::REG_FREQ_FACTOR: r_ff <= i_cfg_data[8:0];
                    sbad_pkg::REG_TIME_OFFSET: r_to <= i_cfg_data[15:0];
                    sbad_pkg::REG_FREQ_OFFSET: r_fo <= i_cfg_data[11:0];
                    sbad_pkg::REG_ROW_POINTS:  r_rp <= i_cfg_data[12:0];
                    sbad_pkg::REG_CHANNELS:    r_ch <= i_cfg_data[4:0];
                    sbad_pkg::REG_TOTAL_ROWS:  r_tr <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (load_out) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
            r_s_cc   <= r_cc;
            r_s_rib  <= r_rib;
            r_s_orc  <= r_orc;
        end
        if (r_state == sbad_pkg::S_CFG_NF && div_done) begin
            r_nf_raw <= div_quot[12:0];
        end
        if (r_state == sbad_pkg::S_CFG_NT && div_done) begin
            r_nt <= div_quot[16:0];
        end
        if (r_state == sbad_pkg::S_CFG_LIM && div_done) begin
            r_nf <= ({4'd0, r_nf_raw} > div_quot[16:0]) ? div_quot[12:0] : r_nf_raw;
        end
        if (r_state == sbad_pkg::S_QDIV && div_done) begin
            r_q   <= div_quot[11:0];
            r_sub <= div_rem[8:0];
            r_idx <= idx_full[AW-1:0];
        end
        if (r_state == sbad_pkg::S_ACC) begin
            r_neg <= sum_new[SW-1];
        end
        if (load_out) begin
            o_average       <= avg_w[sbad_pkg::AVG_W-1:0];
            o_out_row       <= r_s_orc;
            o_out_point     <= r_q;
            o_channel_index <= r_s_cc;
            o_end_of_row    <= ({1'b0, r_q} == r_nf - 13'd1) && ({1'b0, r_s_cc} == ch_c - 5'd1);
        end
    end

`ifndef SYNTHESIS
    // accumulator index stays inside the output row
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbad_pkg::S_READ) |-> ({1'b0, r_q} < r_nf))
        else $error("box index beyond output row");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> !(o_out_valid && i_out_stall))
        else $error("output register overwritten");

    // write back only follows a read of the same entry
    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> $past(mem_re) && $stable(r_idx))
        else $error("write back without preceding read");
`endif

endmodule
